[rtl/core/xor_multiply_keystream_cipher_core_macros.svh]
// ----------------------------------------------------------------------------
// xor multiply keystream cipher assertion macros
// shared property wrappers for the cipher core checks
// ----------------------------------------------------------------------------
`ifndef XOR_MULTIPLY_KEYSTREAM_CIPHER_CORE_MACROS_SVH
`define XOR_MULTIPLY_KEYSTREAM_CIPHER_CORE_MACROS_SVH

// same-cycle implication
`define XMK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xmk check failed (same cycle)");

// next-cycle implication
`define XMK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xmk check failed (next cycle)");

`endif

[rtl/core/xmk_pkg.sv]
// ----------------------------------------------------------------------------
// xmk_pkg
// shared widths, state types and codes of the keystream cipher core
// ----------------------------------------------------------------------------
package xmk_pkg;

    localparam int WORD_W            = 32;
    localparam int BYTE_W            = 8;
    localparam int WORD_BYTES        = WORD_W / BYTE_W;
    localparam int NUM_WORDS         = 16;
    localparam int NUM_PAIRS         = 6;
    localparam int SEED_WORDS        = 8;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 2;
    localparam int COUNT_W           = 3;
    localparam int WARMUP_ROUNDS_DEF = 16;

    // tail words mixed after the pair updates
    localparam int TAIL_0 = 2 * NUM_PAIRS;
    localparam int TAIL_1 = TAIL_0 + 1;
    localparam int TAIL_2 = TAIL_0 + 2;
    localparam int TAIL_3 = TAIL_0 + 3;

    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef struct packed {
        logic [NUM_WORDS-1:0][WORD_W-1:0] words;
        word_t                            accum_a;
        word_t                            accum_b;
    } mix_state_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SEED_LOW   = 2'd0,
        CFG_SEED_HIGH  = 2'd1,
        CFG_MIX_SEED_A = 2'd2,
        CFG_MIX_SEED_B = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_RESTART = 1'b0,
        CMD_CIPHER  = 1'b1
    } cmd_t;

endpackage

[rtl/core/xmk_round.sv]
// ----------------------------------------------------------------------------
// xmk_round
// one mixing round: six pair updates with multiply by 131, tail word mixing
// ----------------------------------------------------------------------------
module xmk_round
(
    input  xmk_pkg::mix_state_t state_in,
    output xmk_pkg::mix_state_t state_out
);
    import xmk_pkg::*;

    localparam word_t MIX_MULT = word_t'(131);
    localparam word_t ONE      = word_t'(1);

    logic [NUM_WORDS-1:0][WORD_W-1:0] words;
    word_t                            acc_a;
    word_t                            acc_b;
    word_t                            lo;
    word_t                            hi;
    word_t                            new_lo;
    word_t                            new_hi;

    always_comb
    begin
        words = state_in.words;
        acc_a = state_in.accum_a;
        acc_b = state_in.accum_b;
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            lo     = state_in.words[k];
            hi     = state_in.words[k + NUM_PAIRS];
            new_lo = lo ^ ((hi + ONE) * MIX_MULT);
            new_hi = (lo + ONE) * MIX_MULT;
            words[k]             = new_lo;
            words[k + NUM_PAIRS] = new_hi;
            acc_a = acc_a ^ new_lo;
            acc_b = acc_b ^ new_hi;
        end
        state_out.words          = words;
        state_out.words[TAIL_0]  = words[TAIL_0] ^ words[TAIL_1];
        state_out.words[TAIL_1]  = words[TAIL_1] ^ words[TAIL_2];
        state_out.words[TAIL_2]  = words[TAIL_2] ^ acc_a;
        state_out.words[TAIL_3]  = words[TAIL_3] ^ acc_b;
        state_out.accum_a        = acc_a;
        state_out.accum_b        = acc_b;
    end

endmodule

[rtl/core/xor_multiply_keystream_cipher_core.sv]
// an accepted word's result is registered in the output register, valid in the next cycle
// throughput: one word per cycle outside warm-up and output stalls; state advances per ciphered word
// restart: its empty result is registered like any word, then warm-up rounds counted down from
// WARMUP_ROUNDS run on the same round unit with the input held off
// reset: asynchronous active low, clears seeds, state, key and output valid
// ----------------------------------------------------------------------------
// xor_multiply_keystream_cipher_core
// 32-bit xor and multiply keystream cipher with seed configuration port
// ----------------------------------------------------------------------------
`include "xor_multiply_keystream_cipher_core_macros.svh"

module xor_multiply_keystream_cipher_core
#(
    parameter int WARMUP_ROUNDS = xmk_pkg::WARMUP_ROUNDS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [xmk_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [xmk_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [xmk_pkg::WORD_W-1:0]       data_in,
    input  logic [xmk_pkg::COUNT_W-1:0]      byte_count,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [xmk_pkg::WORD_W-1:0]       data_out,
    output logic [xmk_pkg::COUNT_W-1:0]      out_count
);
    import xmk_pkg::*;

    localparam int CNT_W = $clog2(WARMUP_ROUNDS + 2);
    localparam count_t FULL_COUNT = count_t'(WORD_BYTES);

    logic [CFG_DATA_W-1:0] seed_low_reg;
    logic [CFG_DATA_W-1:0] seed_high_reg;
    logic [BYTE_W-1:0]     mix_seed_a_reg;
    logic [BYTE_W-1:0]     mix_seed_b_reg;

    mix_state_t            state_reg;
    mix_state_t            state_next;
    mix_state_t            round_out;
    mix_state_t            seed_state;
    word_t                 key_reg;
    word_t                 key_next;
    logic [CNT_W-1:0]      warm_cnt_reg;
    logic [CNT_W-1:0]      warm_cnt_next;

    logic                  out_valid_reg;
    word_t                 data_out_reg;
    count_t                out_count_reg;

    logic                  busy;
    logic                  in_fire;
    logic                  is_restart;
    logic                  is_cipher;
    logic                  restart_fire;
    count_t                count_sat;
    word_t                 lane_mask;
    word_t                 cipher_word;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_low_reg   <= '0;
            seed_high_reg  <= '0;
            mix_seed_a_reg <= '0;
            mix_seed_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SEED_LOW:   seed_low_reg   <= cfg_data;
                CFG_SEED_HIGH:  seed_high_reg  <= cfg_data;
                CFG_MIX_SEED_A: mix_seed_a_reg <= cfg_data[BYTE_W-1:0];
                CFG_MIX_SEED_B: mix_seed_b_reg <= cfg_data[BYTE_W-1:0];
            endcase
        end
    end

    xmk_round u_round
    (
        .state_in  (state_reg),
        .state_out (round_out)
    );

    assign busy         = (warm_cnt_reg != '0);
    assign in_ready     = !busy && (!out_valid_reg || out_ready);
    assign in_fire      = in_valid && in_ready;
    assign is_restart   = (cmd_t'(command) == CMD_RESTART);
    assign count_sat    = (byte_count > FULL_COUNT) ? FULL_COUNT : byte_count;
    assign is_cipher    = !is_restart && (byte_count != '0);
    assign restart_fire = in_fire && is_restart;

    // seed unpacking, one byte per state word
    always_comb
    begin
        for (int j = 0; j < SEED_WORDS; j++)
        begin
            seed_state.words[j]              = word_t'(seed_low_reg[j*BYTE_W +: BYTE_W]);
            seed_state.words[j + SEED_WORDS] = word_t'(seed_high_reg[j*BYTE_W +: BYTE_W]);
        end
        seed_state.accum_a = word_t'(mix_seed_a_reg);
        seed_state.accum_b = word_t'(mix_seed_b_reg);
    end

    always_comb
    begin
        for (int b = 0; b < WORD_BYTES; b++)
        begin
            lane_mask[b*BYTE_W +: BYTE_W] = {BYTE_W{count_sat > count_t'(b)}};
        end
    end

    assign key_next    = key_reg ^ round_out.words[TAIL_0] ^ round_out.words[TAIL_1]
                       ^ round_out.words[TAIL_2] ^ round_out.words[TAIL_3];
    assign cipher_word = (data_in ^ key_next) & lane_mask;

    always_comb
    begin
        state_next    = state_reg;
        warm_cnt_next = warm_cnt_reg;
        if (busy)
        begin
            state_next    = round_out;
            warm_cnt_next = warm_cnt_reg - CNT_W'(1);
        end
        else if (in_fire && is_restart)
        begin
            state_next    = seed_state;
            warm_cnt_next = CNT_W'(WARMUP_ROUNDS);
        end
        else if (in_fire && is_cipher)
        begin
            state_next = round_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= '0;
            key_reg      <= '0;
            warm_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            warm_cnt_reg <= warm_cnt_next;
            if (in_fire && is_restart)
            begin
                key_reg <= '0;
            end
            else if (in_fire && is_cipher)
            begin
                key_reg <= key_next;
            end
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            data_out_reg  <= '0;
            out_count_reg <= '0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
            data_out_reg  <= is_cipher ? cipher_word : '0;
            out_count_reg <= is_cipher ? count_sat : '0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign out_count = out_count_reg;

    `XMK_ASSERT_NOW(a_no_accept_in_warmup, busy, !in_ready)
    `XMK_ASSERT_NEXT(a_restart_loads_count, restart_fire, warm_cnt_reg == CNT_W'(WARMUP_ROUNDS))
    `XMK_ASSERT_NEXT(a_restart_empty, restart_fire, out_valid && {data_out, out_count} == '0)
    `XMK_ASSERT_NOW(a_count_in_range, out_valid, out_count <= FULL_COUNT)

endmodule

[bench/xor_multiply_keystream_cipher_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xor_multiply_keystream_cipher_core_tb
// Self-checking bench for the keystream cipher core. A short directed table
// covers restart, short words, zero and saturated counts and data extremes,
// then several seed settings are loaded and random word streams are run, with
// idle gaps on both channels outside phases 2 and 5. Results are checked against
// a behavioural model of the mixing rounds and the running key, or against the fixed result of directed rows.
// ----------------------------------------------------------------------------
module xor_multiply_keystream_cipher_core_tb;

    import xmk_pkg::*;

    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_WORDS = 229;
    localparam int          STALL_LIMIT = 4000;
    localparam int          DIRECTED_N  = 20;
    localparam logic [31:0] MIX_MULT    = 32'd131;

    typedef struct packed {
        word_t  data;
        count_t cnt;
    } cipher_out_t;

    typedef struct packed {
        cmd_t        cmd;
        word_t       data;
        count_t      cnt;
        logic        fixed;
        cipher_out_t res;
    } stim_row_t;

    localparam cipher_out_t ZERO_RESULT = '0;

    // restart and zero-count rows carry their result, the rest go to the model
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
        '{CMD_CIPHER,  32'h0000_0000, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd0, 1'b1, ZERO_RESULT},
        '{CMD_RESTART, 32'hFFFF_FFFF, 3'd7, 1'b1, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd1, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd2, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd3, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFFFF_FFFF, 3'd5, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'h1234_5678, 3'd6, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hA5A5_A5A5, 3'd7, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'h0000_0000, 3'd0, 1'b1, ZERO_RESULT},
        '{CMD_RESTART, 32'h0000_0000, 3'd0, 1'b1, ZERO_RESULT},
        '{CMD_CIPHER,  32'h0000_0000, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'h0000_0000, 3'd1, 1'b0, ZERO_RESULT},
        '{CMD_RESTART, 32'hDEAD_BEEF, 3'd4, 1'b1, ZERO_RESULT},
        '{CMD_RESTART, 32'h0000_0001, 3'd1, 1'b1, ZERO_RESULT},
        '{CMD_CIPHER,  32'h5A5A_5A5A, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'h8000_0000, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'h0000_0001, 3'd4, 1'b0, ZERO_RESULT},
        '{CMD_CIPHER,  32'hFF00_0000, 3'd3, 1'b0, ZERO_RESULT}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    logic                   command;
    word_t                  data_in;
    count_t                 byte_count;
    logic                   out_valid;
    logic                   out_ready;
    word_t                  data_out;
    count_t                 out_count;

    // model state and seed mirror
    word_t           ks_words [NUM_WORDS];
    word_t           ks_acc_a;
    word_t           ks_acc_b;
    word_t           ks_key;
    logic [63:0]     key_seed_lo;
    logic [63:0]     key_seed_hi;
    logic [7:0]      acc_seed_a;
    logic [7:0]      acc_seed_b;

    cipher_out_t     pending_words [$];
    int              mismatch_count;
    bit              no_gaps;
    int unsigned     ready_hold;

    xor_multiply_keystream_cipher_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .data_in    (data_in),
        .byte_count (byte_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .data_out   (data_out),
        .out_count  (out_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void mix_round();
        word_t lo;
        word_t hi;
        word_t new_lo;
        word_t new_hi;
        for (int k = 0; k < NUM_PAIRS; k++)
        begin
            lo     = ks_words[k];
            hi     = ks_words[k + NUM_PAIRS];
            new_lo = lo ^ ((hi + 32'd1) * MIX_MULT);
            new_hi = (lo + 32'd1) * MIX_MULT;
            ks_words[k]             = new_lo;
            ks_words[k + NUM_PAIRS] = new_hi;
            ks_acc_a ^= new_lo;
            ks_acc_b ^= new_hi;
        end
        ks_words[TAIL_0] ^= ks_words[TAIL_1];
        ks_words[TAIL_1] ^= ks_words[TAIL_2];
        ks_words[TAIL_2] ^= ks_acc_a;
        ks_words[TAIL_3] ^= ks_acc_b;
    endfunction

    function automatic cipher_out_t cipher_word(cmd_t c, word_t d, count_t n);
        cipher_out_t r;
        int unsigned bytes;
        word_t       mask;
        r = '0;
        if (c == CMD_RESTART)
        begin
            for (int j = 0; j < SEED_WORDS; j++)
            begin
                ks_words[j]              = {24'd0, key_seed_lo[8*j +: 8]};
                ks_words[j + SEED_WORDS] = {24'd0, key_seed_hi[8*j +: 8]};
            end
            ks_acc_a = {24'd0, acc_seed_a};
            ks_acc_b = {24'd0, acc_seed_b};
            ks_key   = '0;
            repeat (WARMUP_ROUNDS_DEF) mix_round();
            return r;
        end
        if (n == 0)
            return r;
        bytes = (n > 4) ? 4 : n;
        mask  = (bytes == 4) ? '1 : ((32'd1 << (8 * bytes)) - 32'd1);
        mix_round();
        ks_key ^= ks_words[TAIL_0] ^ ks_words[TAIL_1] ^ ks_words[TAIL_2] ^ ks_words[TAIL_3];
        r.data = (d ^ ks_key) & mask;
        r.cnt  = count_t'(bytes);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned pick;
        if (no_gaps)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_SEED_LOW:   key_seed_lo = val;
            CFG_SEED_HIGH:  key_seed_hi = val;
            CFG_MIX_SEED_A: acc_seed_a  = val[7:0];
            CFG_MIX_SEED_B: acc_seed_b  = val[7:0];
            default: ;
        endcase
    endtask

    task automatic send_word(cmd_t c, word_t d, count_t n, logic fixed, cipher_out_t res);
        cipher_out_t want;
        int unsigned gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        command    <= c;
        data_in    <= d;
        byte_count <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        want = cipher_word(c, d, n);
        pending_words.push_back(fixed ? res : want);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random_word();
        int unsigned pick;
        cmd_t        c;
        word_t       d;
        count_t      n;
        pick = $urandom_range(0, 99);
        c    = CMD_CIPHER;
        d    = $urandom;
        n    = count_t'($urandom_range(1, 4));
        if (pick < 4)
            c = CMD_RESTART;
        else if (pick < 8)
            n = '0;
        else if (pick < 12)
            n = count_t'($urandom_range(5, 7));
        else if (pick < 16)
            d = pick[0] ? '1 : '0;
        send_word(c, d, n, 1'b0, ZERO_RESULT);
    endtask

    // let the block drain and finish any warm-up before touching the seeds
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (WARMUP_ROUNDS_DEF + 4) @(posedge clk);
    endtask

    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (ready_hold > 0)
            begin
                out_ready <= 1'b0;
                ready_hold--;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        cipher_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
                report_mismatch("result with no word pending", data_out, '0);
            else
            begin
                want = pending_words.pop_front();
                if (data_out !== want.data)
                    report_mismatch("data_out", data_out, want.data);
                if (out_count !== want.cnt)
                    report_mismatch("out_count", word_t'(out_count), word_t'(want.cnt));
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge rst_n);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        logic [63:0] lo_val;
        logic [63:0] hi_val;
        logic [63:0] a_val;
        logic [63:0] b_val;
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        command        = 1'b0;
        data_in        = '0;
        byte_count     = '0;
        mismatch_count = 0;
        no_gaps        = 1'b0;
        ready_hold     = 0;
        key_seed_lo    = '0;
        key_seed_hi    = '0;
        acc_seed_a     = '0;
        acc_seed_b     = '0;
        ks_acc_a       = '0;
        ks_acc_b       = '0;
        ks_key         = '0;
        foreach (ks_words[i])
            ks_words[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_N; i++)
            send_word(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].cnt,
                      DIRECTED_ROWS[i].fixed, DIRECTED_ROWS[i].res);

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            settle();
            case (phase)
                1:
                begin
                    lo_val = '1;
                    hi_val = '1;
                    a_val  = '1;
                    b_val  = '1;
                end
                2:
                begin
                    lo_val = '0;
                    hi_val = '0;
                    a_val  = '0;
                    b_val  = '0;
                end
                3:
                begin
                    lo_val = '1;
                    hi_val = '0;
                    a_val  = {$urandom, 24'($urandom_range(0, 16777215)), 8'h00};
                    b_val  = {$urandom, 24'($urandom_range(0, 16777215)), 8'hFF};
                end
                default:
                begin
                    lo_val = {$urandom, $urandom};
                    hi_val = {$urandom, $urandom};
                    a_val  = {$urandom, $urandom};
                    b_val  = {$urandom, $urandom};
                end
            endcase
            write_reg(CFG_SEED_LOW, lo_val);
            write_reg(CFG_SEED_HIGH, hi_val);
            write_reg(CFG_MIX_SEED_A, a_val);
            write_reg(CFG_MIX_SEED_B, b_val);
            @(negedge clk);
            cfg_we <= 1'b0;
            no_gaps = (phase == 2 || phase == 5);

            send_word(CMD_RESTART, $urandom, count_t'($urandom_range(0, 7)), 1'b0, ZERO_RESULT);
            for (int i = 1; i < PHASE_WORDS; i++)
                send_random_word();
        end

        settle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/xmk_pkg.sv
rtl/core/xmk_round.sv
rtl/core/xor_multiply_keystream_cipher_core.sv
bench/xor_multiply_keystream_cipher_core_tb.sv
